FILE: sv/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg - shared types and constants for the pressure trend window
// Sequencer states, trend codes, defaults and the interval-to-window table.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_W        = 16;
    localparam int INTERVAL_W      = 6;
    localparam int TREND_W         = 2;
    localparam int WIN_TBL_W       = 8;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 6'd5;

    localparam logic [TREND_W-1:0] TREND_FALLING = 2'd0;
    localparam logic [TREND_W-1:0] TREND_STEADY  = 2'd1;
    localparam logic [TREND_W-1:0] TREND_RISING  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_FINISH
    } t_state;

    // 4 * (60 / interval); zero for an interval of zero or above sixty
    function automatic logic [WIN_TBL_W-1:0] window_for_interval(
        input logic [INTERVAL_W-1:0] interval
    );
        logic [WIN_TBL_W-1:0] win;
        case (interval) inside
            6'd1:           win = 8'd240;
            6'd2:           win = 8'd120;
            6'd3:           win = 8'd80;
            6'd4:           win = 8'd60;
            6'd5:           win = 8'd48;
            6'd6:           win = 8'd40;
            6'd7:           win = 8'd32;
            6'd8:           win = 8'd28;
            [6'd9:6'd10]:   win = 8'd24;
            [6'd11:6'd12]:  win = 8'd20;
            [6'd13:6'd15]:  win = 8'd16;
            [6'd16:6'd20]:  win = 8'd12;
            [6'd21:6'd30]:  win = 8'd8;
            [6'd31:6'd60]:  win = 8'd4;
            default:        win = 8'd0;
        endcase
        return win;
    endfunction

endpackage

FILE: sv/ptw_sample_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_sample_ram - sample ring store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptw_sample_ram
    import ptw_pkg::*;
#(
    parameter int DEPTH = MAX_SAMPLES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pressure_trend_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_trend_window_unit - barometric trend over a sliding sample window
// Stores each sample in a ring, sums the filled entries and compares the
// sample times the fill count with that sum: falling, steady or rising.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  sample   | in        | i_in_valid / o_in_stall    | i_pressure_sample
//  trend    | out       | o_out_valid / i_out_stall  | o_trend
//  config   | in        | i_cfg_we (no wait)         | i_cfg_data (interval)
//
//  Steps per sample: accept and write, one read per filled entry through
//    the single RAM read port, the read data arriving from the RAM
//    register, seeing the reads done, and the compare/load step; with a
//    zero window there are no reads.
//  One sample transaction is in work at a time; o_in_stall is high from
//    accept until the result is loaded into the output register.
//  A stalled result waits in the output register while the next sample is
//    accepted; the compare cycle holds only if that register is still full.
//  Reset (synchronous, active low) clears sequencer, index and fill count;
//    the RAM needs no clearing pass since only written entries are read.
//  A config write clears index and count and recomputes the window.
// ----------------------------------------------------------------------------
module pressure_trend_window_unit
    import ptw_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_pressure_sample,
    // trend channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TREND_W-1:0]    o_trend,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [INTERVAL_W-1:0] i_cfg_data
);

    localparam int W_IDX = $clog2(MAX_SAMPLES);
    localparam int W_CNT = $clog2(MAX_SAMPLES + 1);
    localparam int W_SUM = SAMPLE_W + W_CNT;
    localparam logic [W_CNT-1:0] MAX_CNT = W_CNT'(MAX_SAMPLES);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [W_CNT-1:0]      r_window;      // window length, limited to depth
    logic [W_IDX-1:0]      r_wp, n_wp;    // ring write index
    logic [W_CNT-1:0]      r_count, n_count;
    logic [W_CNT-1:0]      r_rd_idx;      // next entry to read
    logic                  r_rd_pend;     // read data arrives this cycle
    logic [SAMPLE_W-1:0]   r_sample;
    logic [W_SUM-1:0]      r_sum;
    logic [W_SUM-1:0]      r_scaled;
    logic                  r_out_valid;
    logic [TREND_W-1:0]    r_trend;

    logic                  in_accept;
    logic                  out_take;
    logic                  rd_issue;
    logic                  out_load;
    logic [SAMPLE_W-1:0]   rd_data;
    logic [W_CNT-1:0]      cfg_window;
    logic [W_CNT-1:0]      wp_inc;
    logic [TREND_W-1:0]    trend_calc;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;

    // Window from the new interval, limited to the store depth
    always_comb begin
        cfg_window = W_CNT'(window_for_interval(i_cfg_data));
        if (cfg_window > MAX_CNT) begin
            cfg_window = MAX_CNT;
        end
    end

    // Index and fill count after this sample is written
    assign wp_inc = W_CNT'(r_wp) + W_CNT'(1);

    always_comb begin
        n_wp = (wp_inc >= r_window) ? '0 : wp_inc[W_IDX-1:0];
        n_count = r_count;
        if (r_count < r_window) begin
            n_count = r_count + W_CNT'(1);
        end
        if (n_count > r_window) begin
            n_count = r_window;
        end
    end

    // ------------------------------------------------------------------
    // Sample store
    // ------------------------------------------------------------------
    ptw_sample_ram #(
        .DEPTH (MAX_SAMPLES),
        .ADDR_W(W_IDX)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (in_accept),
        .i_waddr(r_wp),
        .i_wdata(i_pressure_sample),
        .i_re   (rd_issue),
        .i_raddr(r_rd_idx[W_IDX-1:0]),
        .o_rdata(rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (!rd_issue && !r_rd_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_issue   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_SUM:    rd_issue   = (r_rd_idx < r_count);
            ST_FINISH: out_load   = !r_out_valid || !i_out_stall;
            default:   o_in_stall = 1'b1;
        endcase
    end

    // Exact mean compare: sample * count against the sum
    always_comb begin
        if (r_scaled < r_sum) begin
            trend_calc = TREND_FALLING;
        end else if (r_scaled > r_sum) begin
            trend_calc = TREND_RISING;
        end else begin
            trend_calc = TREND_STEADY;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= W_CNT'(window_for_interval(INTERVAL_RESET));
            r_wp        <= '0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_issue;
            if (i_cfg_we) begin
                r_window   <= cfg_window;
                r_wp       <= '0;
                r_count    <= '0;
            end else if (in_accept) begin
                r_wp    <= n_wp;
                r_count <= n_count;
            end
            if (in_accept) begin
                r_rd_idx <= '0;
            end else if (rd_issue) begin
                r_rd_idx <= r_rd_idx + W_CNT'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_pressure_sample;
            r_sum    <= '0;
        end else if (r_rd_pend) begin
            r_sum <= r_sum + W_SUM'(rd_data);
        end
        if (r_state == ST_SUM) begin
            r_scaled <= W_SUM'(r_sample) * W_SUM'(r_count);
        end
        if (out_load) begin
            r_trend <= trend_calc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_trend     = r_trend;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_window)
        else $error("fill count exceeds window");

    a_wp_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (W_CNT'(r_wp) < r_window) || (r_wp == '0))
        else $error("write index outside window");

    a_accept_starts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_SUM))
        else $error("accepted sample did not start summing");

    a_reads_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_rd_idx <= r_count))
        else $error("read index ran past fill count");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> !i_out_stall)
        else $error("result loaded over a waiting result");

endmodule

FILE: sim/pressure_trend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_trend_checker - trend predictor and result checker
// Watches the sample, trend and config ports of the trend window unit, keeps
// its own copy of the sample window and compares each trend transaction with
// the oldest predicted trend.
// ----------------------------------------------------------------------------
module pressure_trend_checker
    import ptw_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [SAMPLE_W-1:0]   i_pressure_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [TREND_W-1:0]    i_trend,
    input  logic                  i_cfg_we,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    output int                    o_error_count,
    output int                    o_trends_outstanding
);

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_WINDOW = 4;

    logic [SAMPLE_W-1:0]   window_mem [MAX_SAMPLES];
    logic [INTERVAL_W-1:0] interval_min;
    logic [8:0]            write_pos;
    logic [8:0]            fill_count;
    logic [TREND_W-1:0]    expected_trends [$];
    logic [TREND_W-1:0]    trend_due;

    function automatic logic [8:0] window_len(input logic [INTERVAL_W-1:0] iv);
        int w;
        if (iv == 0 || iv > MINUTES_PER_HOUR) begin
            return '0;
        end
        w = HOURS_PER_WINDOW * (MINUTES_PER_HOUR / iv);
        if (w > MAX_SAMPLES) begin
            w = MAX_SAMPLES;
        end
        return w[8:0];
    endfunction

    task automatic clear_window();
        foreach (window_mem[i]) begin
            window_mem[i] = '0;
        end
        write_pos  = '0;
        fill_count = '0;
    endtask

    // store the sample, advance the ring, then compare sample*count with sum
    function automatic logic [TREND_W-1:0] predict_trend(input logic [SAMPLE_W-1:0] s);
        logic [8:0]  win;
        logic [31:0] sum;
        logic [31:0] scaled;
        win = window_len(interval_min);
        if (write_pos >= MAX_SAMPLES) begin
            write_pos = '0;
        end
        window_mem[write_pos] = s;
        write_pos = write_pos + 9'd1;
        if (write_pos >= win) begin
            write_pos = '0;
        end
        if (fill_count < win) begin
            fill_count = fill_count + 9'd1;
        end
        if (fill_count > win) begin
            fill_count = win;
        end
        // zero window: nothing to average against
        if (fill_count == 0) begin
            return TREND_STEADY;
        end
        sum = '0;
        for (int i = 0; i < fill_count; i++) begin
            sum = sum + window_mem[i];
        end
        scaled = s * fill_count;
        if (scaled < sum) begin
            return TREND_FALLING;
        end else if (scaled > sum) begin
            return TREND_RISING;
        end
        return TREND_STEADY;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            interval_min = INTERVAL_RESET;
            clear_window();
            expected_trends.delete();
            o_error_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_trends.size() == 0) begin
                    $error("trend: expected none, actual %0d", i_trend);
                    o_error_count++;
                end else begin
                    trend_due = expected_trends.pop_front();
                    if (i_trend !== trend_due) begin
                        $error("trend: expected %0d, actual %0d", trend_due, i_trend);
                        o_error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                interval_min = i_cfg_data;
                clear_window();
            end
            if (i_in_valid && !i_in_stall) begin
                expected_trends.push_back(predict_trend(i_pressure_sample));
            end
        end
        o_trends_outstanding = expected_trends.size();
    end

endmodule

FILE: sim/pressure_trend_window_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_trend_window_unit_tb - testbench for the pressure trend window
// Feeds barometer samples in bursts under a range of sample intervals, stalls
// the trend channel on its own pattern and lets the checker predict and
// compare every trend transaction.
// ----------------------------------------------------------------------------
module pressure_trend_window_unit_tb;
    import ptw_pkg::*;

    // The receiver's long hold-off is well under the watchdog limit, so only a
    // hang trips it.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 1500;
    localparam int HOLD_AFTER     = 200;   // trend transactions before hold-off
    localparam int DRAIN_CYCLES   = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_pressure_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [TREND_W-1:0]    o_trend;
    logic                  i_cfg_we;
    logic [INTERVAL_W-1:0] i_cfg_data;

    int error_count;
    int trends_outstanding;
    int idle_cycles;

    logic [SAMPLE_W-1:0] directed_samples [18];

    always #10 i_clk = ~i_clk;

    pressure_trend_window_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pressure_sample (i_pressure_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_trend           (o_trend),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data)
    );

    pressure_trend_checker checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_pressure_sample    (i_pressure_sample),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_trend              (o_trend),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .o_error_count        (error_count),
        .o_trends_outstanding (trends_outstanding)
    );

    // Offer one sample and hold it until it is accepted.
    // Returns at the accepting edge with valid still high.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        i_in_valid        <= 1'b1;
        i_pressure_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Mostly values near a burst base so that steady trends and long runs of
    // equal readings show up; every fourth pick or so spans the full range.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 3))
            0:       s = SAMPLE_W'($urandom());
            1:       s = base;
            default: s = base + SAMPLE_W'($urandom_range(0, 3)) - SAMPLE_W'(1);
        endcase
        return s;
    endfunction

    // Bursts of random length; about a third end with no gap at all.
    task automatic feed_samples(input int count);
        int                  sent;
        int                  burst;
        int                  gap;
        logic [SAMPLE_W-1:0] base;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            base  = SAMPLE_W'($urandom());
            for (int k = 0; k < burst && sent < count; k++) begin
                send_sample(pick_sample(base));
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0 || sent >= count) begin
                i_in_valid <= 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every sample yields one trend, so an empty expectation list means the
    // unit has nothing in work.
    task automatic wait_drained();
        do @(posedge i_clk); while (trends_outstanding != 0);
    endtask

    task automatic write_interval(input logic [INTERVAL_W-1:0] minutes);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= minutes;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [INTERVAL_W-1:0] minutes, input int count);
        write_interval(minutes);
        feed_samples(count);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sender and phase sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_pressure_sample <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset interval (48-entry window): first sample alone is
        // steady, then range extremes, single-bit and alternating patterns,
        // and repeats.
        directed_samples = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001,
                             16'h8000, 16'h7FFF, 16'hFFFE, 16'h5555, 16'hAAAA,
                             16'h0000, 16'hFFFF, 16'h1234, 16'h1234, 16'h1234,
                             16'h0002, 16'hFFFF, 16'h8001};
        foreach (directed_samples[i]) begin
            send_sample(directed_samples[i]);
        end
        feed_samples(150);
        wait_drained();

        run_phase(6'd1, 320);   // widest window, wraps past 240
        run_phase(6'd60, 60);   // narrowest real window of 4
        run_phase(6'd0, 40);    // zero window: steady only
        run_phase(6'd2, 160);
        run_phase(6'd63, 30);   // above sixty: zero window
        run_phase(6'd61, 20);
        run_phase(6'd13, 60);
        run_phase(6'd31, 30);
        run_phase(6'd30, 40);
        repeat (3) begin
            run_phase(INTERVAL_W'($urandom_range(1, 60)), 80);
        end

        // let any stray trend show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && trends_outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: segments of random stall behavior, plus one long hold-off
    // mid-run so the output register fills and the sample channel backs up.
    // ------------------------------------------------------------------
    initial begin
        int   seg_len;
        int   mode;
        int   trends_taken;
        logic held_off;
        trends_taken = 0;
        held_off     = 1'b0;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            repeat (seg_len) begin
                if (!held_off && trends_taken >= HOLD_AFTER) begin
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    held_off = 1'b1;
                end
                case (mode)
                    0:       i_out_stall <= 1'b0;                          // free flow
                    1:       i_out_stall <= 1'($urandom_range(0, 1));
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);  // mostly stalled
                    default: i_out_stall <= ~i_out_stall;                  // alternate
                endcase
                @(posedge i_clk);
                if (o_out_valid && !i_out_stall) begin
                    trends_taken++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
